FILE: src/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg: shared types and constants for the CO2 PWM averager
// Field widths, register indexes, reset values, sequencer states and the
// request/response bundles that travel between the sequencer and its units.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int unsigned PPM_W      = 14;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WARM_W     = 16;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Divider geometry: dividend is full_scale * (high - 2), divisor the
  // positive denominator; the quotient never exceeds the ppm width.
  localparam int unsigned QUOT_W     = PPM_W;
  localparam int unsigned DEN_W      = TIME_W + 2;
  localparam int unsigned DIVIDEND_W = PPM_W + TIME_W;

  localparam int unsigned WINDOW_DEPTH_DEF = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_ON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_OFF    = 3'd4;

  localparam logic [PPM_W-1:0]  FULL_SCALE_RST = 14'd5000;
  localparam logic [PPM_W-1:0]  ALARM_RST      = 14'd1000;
  localparam logic [WARM_W-1:0] WARMUP_RST     = 16'd10000;
  localparam logic [DUTY_W-1:0] LED_ON_RST     = 8'd205;
  localparam logic [DUTY_W-1:0] LED_OFF_RST    = 8'd255;

  // Pulse shaping offsets of the sensor formula
  localparam logic [DEN_W:0] HIGH_OFFSET = 35'd2;
  localparam logic [DEN_W:0] DEN_OFFSET  = 35'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV_RAW,
    ST_RING_RD,
    ST_RING_WR,
    ST_AVG_GO,
    ST_DIV_AVG,
    ST_COLOUR,
    ST_FINISH
  } pcpa_state_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DEN_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } win_ctrl_t;

endpackage

FILE: src/pcpa_divider.sv
// ----------------------------------------------------------------------------
// pcpa_divider: shared restoring divider
// One quotient bit per cycle; the caller guarantees the quotient fits QUOT_W.
// ----------------------------------------------------------------------------
module pcpa_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcpa_pkg::div_req_t req_i,
  output pcpa_pkg::div_rsp_t rsp_o
);
  import pcpa_pkg::*;

  localparam int unsigned CntW = $clog2(QUOT_W + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  dvs_q;
  logic [QUOT_W-1:0] low_q;
  logic [QUOT_W-1:0] quo_q;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  assign trial = {rem_q, low_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QUOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= DEN_W'(req_i.dividend[DIVIDEND_W-1:QUOT_W]);
      low_q <= req_i.dividend[QUOT_W-1:0];
      dvs_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_q <= {low_q[QUOT_W-2:0], 1'b0};
      quo_q <= {quo_q[QUOT_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: src/pcpa_window.sv
// ----------------------------------------------------------------------------
// pcpa_window: reading ring with running sum
// Holds the last Depth readings, the write slot, the fill flag and the sum.
// ----------------------------------------------------------------------------
module pcpa_window #(
  parameter int unsigned Depth = pcpa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcpa_pkg::win_ctrl_t         ctrl_i,
  input  logic [pcpa_pkg::PPM_W-1:0]  value_i,
  output logic [pcpa_pkg::PPM_W+$clog2(Depth+1)-1:0] sum_o,
  output logic [$clog2(Depth+1)-1:0]  count_o
);
  import pcpa_pkg::*;

  localparam int unsigned SlotW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned SumW  = PPM_W + CntW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(Depth - 1);

  logic [PPM_W-1:0] mem [Depth];
  logic [PPM_W-1:0] rd_q;
  logic [SlotW-1:0] slot_q;
  logic             full_q;
  logic [SumW-1:0]  sum_q;
  logic [SumW-1:0]  sum_d;
  logic [CntW-1:0]  count;

  // Retire the oldest entry only once the ring has wrapped
  assign sum_d = sum_q - (full_q ? SumW'(rd_q) : '0) + SumW'(value_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[slot_q] <= value_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      full_q <= 1'b0;
      sum_q  <= '0;
    end else if (ctrl_i.wr_en) begin
      sum_q <= sum_d;
      if (slot_q == LastSlot) begin
        slot_q <= '0;
        full_q <= 1'b1;
      end else begin
        slot_q <= slot_q + SlotW'(1);
      end
    end
  end

  always_comb begin
    count = full_q ? CntW'(Depth) : CntW'(slot_q);
    if (count == '0) begin
      count = CntW'(1);
    end
  end

  assign sum_o   = sum_q;
  assign count_o = count;

endmodule

FILE: src/pwm_co2_ppm_averager.sv
// ----------------------------------------------------------------------------
// pwm_co2_ppm_averager: CO2 sensor PWM decoder with moving average and LED
// Watches the sensor level for edges, converts each high pulse to ppm,
// averages the last readings and picks the status colour.
// ----------------------------------------------------------------------------
// Sequence: a sample without a falling edge goes from idle straight to the
//   finish state; a falling edge passes twice through the shared bit-serial
//   divider, once when the reading is degenerate or saturated.
// Throughput: one sample at a time; in_ready_o is high only in idle.
// Reset: registers return to their reset values, duties 255, average 0;
//   the reading ring needs no clearing pass.
module pwm_co2_ppm_averager #(
  parameter int unsigned WindowDepth = pcpa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [pcpa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pcpa_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // sample request
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              switch_on_i,
  input  logic                              sensor_level_i,
  input  logic [pcpa_pkg::TIME_W-1:0]       time_ms_i,
  // result request
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pcpa_pkg::DUTY_W-1:0]       red_duty_o,
  output logic [pcpa_pkg::DUTY_W-1:0]       green_duty_o,
  output logic [pcpa_pkg::DUTY_W-1:0]       blue_duty_o,
  output logic [pcpa_pkg::PPM_W-1:0]        average_ppm_o,
  output logic                              new_average_o
);
  import pcpa_pkg::*;

  localparam int unsigned CntW = $clog2(WindowDepth + 1);
  localparam int unsigned SumW = PPM_W + CntW;

  // configuration registers
  logic [PPM_W-1:0]  full_q;
  logic [PPM_W-1:0]  alarm_q;
  logic [WARM_W-1:0] warm_q;
  logic [DUTY_W-1:0] on_q;
  logic [DUTY_W-1:0] off_q;

  // edge tracking state
  logic              prev_q;
  logic [TIME_W-1:0] rise_q;
  logic [TIME_W-1:0] fall_q;
  logic [TIME_W-1:0] low_q;

  // held results
  logic [DUTY_W-1:0] red_q, green_q, blue_q;
  logic [PPM_W-1:0]  avg_q;

  // per-request working registers
  logic [TIME_W-1:0] time_q;
  logic [TIME_W-1:0] high_q;
  logic              fresh_q;
  logic [TIME_W-1:0] num_q;
  logic [DEN_W-1:0]  den_q;
  logic [PPM_W-1:0]  raw_q;

  // output register
  logic              out_valid_q;
  logic [DUTY_W-1:0] out_red_q, out_green_q, out_blue_q;
  logic [PPM_W-1:0]  out_avg_q;
  logic              out_new_q;

  pcpa_state_e state_q, state_d;

  logic in_fire;
  logic falling;
  logic out_load;

  logic signed [DEN_W:0] num_s;
  logic signed [DEN_W:0] den_s;
  logic                  num_pos;
  logic                  den_pos;
  logic                  degen;
  logic                  sat;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  win_ctrl_t win_ctrl;
  logic [SumW-1:0] win_sum;
  logic [CntW-1:0] win_count;

  assign in_fire  = in_valid_i && in_ready_o;
  assign falling  = switch_on_i && !sensor_level_i && prev_q;
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // Signed pulse terms: high-2 and high+low-4, each widened to stay exact
  assign num_s   = $signed({3'b000, high_q}) - $signed(HIGH_OFFSET);
  assign den_s   = $signed({3'b000, high_q}) + $signed({3'b000, low_q})
                 - $signed(DEN_OFFSET);
  assign num_pos = !num_s[DEN_W] && (num_s != '0);
  assign den_pos = !den_s[DEN_W] && (den_s != '0);
  assign degen   = !num_pos || !den_pos;
  // high-2 at or above the denominator means the ratio is at least one
  assign sat     = (num_s >= den_s);

  pcpa_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pcpa_window #(
    .Depth (WindowDepth)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .value_i (raw_q),
    .sum_o   (win_sum),
    .count_o (win_count)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = falling ? ST_PREP : ST_FINISH;
        end
      end
      ST_PREP: begin
        state_d = (degen || sat) ? ST_RING_RD : ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_DIV_RAW;
      end
      ST_DIV_RAW: begin
        if (div_rsp.done) begin
          state_d = ST_RING_RD;
        end
      end
      ST_RING_RD: begin
        state_d = ST_RING_WR;
      end
      ST_RING_WR: begin
        state_d = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        state_d = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_rsp.done) begin
          state_d = ST_COLOUR;
        end
      end
      ST_COLOUR: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs to the shared divider and the ring
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIVIDEND_W'(win_sum);
    div_req.divisor  = DEN_W'(win_count);
    win_ctrl.rd_en   = 1'b0;
    win_ctrl.wr_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_MUL: begin
        // Product goes straight into the divider's own registers
        div_req.start    = 1'b1;
        div_req.dividend = DIVIDEND_W'(full_q) * DIVIDEND_W'(num_q);
        div_req.divisor  = den_q;
      end
      ST_RING_RD: begin
        win_ctrl.rd_en = 1'b1;
      end
      ST_RING_WR: begin
        win_ctrl.wr_en = 1'b1;
      end
      ST_AVG_GO: begin
        div_req.start = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control and held state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      full_q      <= FULL_SCALE_RST;
      alarm_q     <= ALARM_RST;
      warm_q      <= WARMUP_RST;
      on_q        <= LED_ON_RST;
      off_q       <= LED_OFF_RST;
      prev_q      <= 1'b0;
      rise_q      <= '0;
      fall_q      <= '0;
      low_q       <= '0;
      red_q       <= LED_OFF_RST;
      green_q     <= LED_OFF_RST;
      blue_q      <= LED_OFF_RST;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Register writes; indexes beyond the list are dropped
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FULL_SCALE: full_q  <= cfg_wdata_i[PPM_W-1:0];
          CFG_ALARM:      alarm_q <= cfg_wdata_i[PPM_W-1:0];
          CFG_WARMUP:     warm_q  <= cfg_wdata_i[WARM_W-1:0];
          CFG_LED_ON:     on_q    <= cfg_wdata_i[DUTY_W-1:0];
          CFG_LED_OFF:    off_q   <= cfg_wdata_i[DUTY_W-1:0];
          default: ;
        endcase
      end

      // Edge detection on the accepted sample; open switch darkens the LED
      if (in_fire) begin
        if (!switch_on_i) begin
          red_q   <= off_q;
          green_q <= off_q;
          blue_q  <= off_q;
        end else if (sensor_level_i && !prev_q) begin
          rise_q <= time_ms_i;
          low_q  <= time_ms_i - fall_q;
          prev_q <= 1'b1;
        end else if (falling) begin
          fall_q <= time_ms_i;
          prev_q <= 1'b0;
        end
      end

      if ((state_q == ST_DIV_AVG) && div_rsp.done) begin
        avg_q <= div_rsp.quotient;
      end

      // Blue during warm-up, then green below the alarm level, else red
      if (state_q == ST_COLOUR) begin
        if (time_q < TIME_W'(warm_q)) begin
          red_q   <= off_q;
          green_q <= off_q;
          blue_q  <= on_q;
        end else if (avg_q < alarm_q) begin
          red_q   <= off_q;
          green_q <= on_q;
          blue_q  <= off_q;
        end else begin
          red_q   <= on_q;
          green_q <= off_q;
          blue_q  <= off_q;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers and output payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      time_q  <= time_ms_i;
      high_q  <= time_ms_i - rise_q;
      fresh_q <= falling;
    end

    if (state_q == ST_PREP) begin
      num_q <= num_s[TIME_W-1:0];
      den_q <= den_s[DEN_W-1:0];
      raw_q <= degen ? '0 : full_q;
    end

    if ((state_q == ST_DIV_RAW) && div_rsp.done) begin
      raw_q <= div_rsp.quotient;
    end

    if (out_load) begin
      out_red_q   <= red_q;
      out_green_q <= green_q;
      out_blue_q  <= blue_q;
      out_avg_q   <= avg_q;
      out_new_q   <= fresh_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_duty_o    = out_red_q;
  assign green_duty_o  = out_green_q;
  assign blue_duty_o   = out_blue_q;
  assign average_ppm_o = out_avg_q;
  assign new_average_o = out_new_q;

endmodule
